FILE: src/qkv_pkg.sv
// Shared types and constants for the query key/value extractor.
// No dependencies; compiled first.
`default_nettype none

package qkv_pkg;

    localparam int CHAR_W        = 8;
    localparam int MAX_KEY_CHARS = 4;
    localparam int KEY_W         = MAX_KEY_CHARS * CHAR_W;           // 32
    localparam int KEY_LEN_W     = 3;
    localparam int KEY_POS_W     = $clog2(MAX_KEY_CHARS);            // 2
    localparam int MAX_VAL_BUF   = 8;
    localparam int VALUE_BYTES   = MAX_VAL_BUF - 1;                  // 7
    localparam int VALUE_W       = VALUE_BYTES * CHAR_W;             // 56
    localparam int VAL_CNT_W     = 3;
    localparam int MAX_VAL_LEN_W = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = KEY_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_CHARS   = 2'd0,
        CFG_KEY_LENGTH  = 2'd1,
        CFG_MAX_VAL_LEN = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    // Scan phase
    typedef enum logic [1:0] {
        PH_SEARCH    = 2'd0,
        PH_EXPECT_EQ = 2'd1,
        PH_CAPTURE   = 2'd2,
        PH_DONE      = 2'd3
    } t_phase;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_QM  = 8'h3F;  // '?'
    localparam logic [CHAR_W-1:0] CH_AMP = 8'h26;  // '&'
    localparam logic [CHAR_W-1:0] CH_EQ  = 8'h3D;  // '='
    localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;  // ' '
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;  // '\r'

    localparam logic [KEY_W-1:0]         RST_KEY_CHARS   = 32'h0000_7773;  // "sw"
    localparam logic [KEY_LEN_W-1:0]     RST_KEY_LENGTH  = 3'd2;
    localparam logic [MAX_VAL_LEN_W-1:0] RST_MAX_VAL_LEN = 4'd5;

endpackage

`default_nettype wire

FILE: src/qkv_if.sv
// Valid/ready stream interfaces for character beats in and result beats out.
// Depends on qkv_pkg.
`default_nettype none

interface qkv_in_if;
    logic                      valid;
    logic                      ready;
    logic [qkv_pkg::CHAR_W-1:0] char_code;
    logic                      first_char;

    modport source (output valid, output char_code, output first_char, input ready);
    modport sink   (input valid, input char_code, input first_char, output ready);
endinterface

interface qkv_out_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [qkv_pkg::VALUE_W-1:0]     value_chars;
    logic [qkv_pkg::VAL_CNT_W-1:0]   value_length;

    modport source (output valid, output found, output value_chars, output value_length,
                    input ready);
    modport sink   (input valid, input found, input value_chars, input value_length,
                    output ready);
endinterface

`default_nettype wire

FILE: src/query_key_value_extractor_core.sv
// Query key/value extractor top level: scan state, config registers, result register.
// Depends on qkv_pkg and the stream interfaces in qkv_if.sv.
`default_nettype none

// One character beat is taken per clock. Each beat updates the scan state
// (phase, key position, previous character, value buffer) through one level of
// compare-and-select logic, and any result it raises sits in the output
// register in the cycle after the beat is accepted. At most one result beat per
// string: found=0 when NUL, space or CR ends the string before "key=" is seen,
// found=1 with the captured value once the value ends ('&', NUL, space, CR) or
// max_value_length-1 characters are held. A key starts only after '?' or '&';
// the first character of a string (first_char=1) has no predecessor. After a
// result, characters are dropped until the next first_char. The input is
// stalled only while an undelivered result holds the output register, so the
// sustained rate is one character per cycle. Configuration writes are meant for
// idle periods only.

module query_key_value_extractor_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    qkv_in_if.sink                         i_in,
    qkv_out_if.source                      o_out,
    input  wire                            i_cfg_we,
    input  wire [qkv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [qkv_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import qkv_pkg::*;

    // Config registers
    logic [KEY_W-1:0]         r_key_chars;
    logic [KEY_LEN_W-1:0]     r_key_length;
    logic [MAX_VAL_LEN_W-1:0] r_max_val_len;

    // Scan state
    t_phase                   r_phase,    n_phase;
    logic [KEY_POS_W-1:0]     r_key_pos,  n_key_pos;
    logic [CHAR_W-1:0]        r_prev,     n_prev;
    logic [VALUE_W-1:0]       r_val_buf,  n_val_buf;
    logic [VAL_CNT_W-1:0]     r_val_cnt,  n_val_cnt;

    // Result register
    logic                     r_out_valid;
    logic                     r_found,    n_found;
    logic [VALUE_W-1:0]       r_out_val;
    logic [VAL_CNT_W-1:0]     r_out_len;
    logic                     n_emit;

    logic                     in_acc;
    logic                     is_end;      // NUL, space or CR
    logic [KEY_LEN_W-1:0]     key_len;     // saturated to MAX_KEY_CHARS
    logic [VAL_CNT_W-1:0]     val_limit;
    logic [MAX_VAL_LEN_W-1:0] mvl_m1;
    logic [KEY_POS_W-1:0]     kp;
    logic [KEY_LEN_W-1:0]     kp_next;
    logic [CHAR_W-1:0]        key_byte;
    logic [CHAR_W-1:0]        c;
    t_phase                   ph;
    logic [KEY_POS_W-1:0]     kpos;
    logic [CHAR_W-1:0]        prev;
    logic [VALUE_W-1:0]       vbuf;
    logic [VAL_CNT_W-1:0]     vcnt;

    // Output register frees up when it is empty or being drained this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_found;
    assign o_out.value_chars  = r_out_val;
    assign o_out.value_length = r_out_len;

    // ---- config-derived limits ----
    always_comb begin
        key_len = (r_key_length > KEY_LEN_W'(MAX_KEY_CHARS))
                  ? KEY_LEN_W'(MAX_KEY_CHARS) : r_key_length;
        mvl_m1  = r_max_val_len - MAX_VAL_LEN_W'(1);
        if (r_max_val_len == '0) begin
            val_limit = '0;
        end else if (mvl_m1 > MAX_VAL_LEN_W'(VALUE_BYTES)) begin
            val_limit = VAL_CNT_W'(VALUE_BYTES);
        end else begin
            val_limit = mvl_m1[VAL_CNT_W-1:0];
        end
    end

    // ---- per-beat next state ----
    always_comb begin
        c = i_in.char_code;
        // first_char restarts the scan before the character is looked at
        if (i_in.first_char) begin
            ph   = PH_SEARCH;
            kpos = '0;
            prev = '0;
            vbuf = '0;
            vcnt = '0;
        end else begin
            ph   = r_phase;
            kpos = r_key_pos;
            prev = r_prev;
            vbuf = r_val_buf;
            vcnt = r_val_cnt;
        end

        is_end = (c == CH_NUL) || (c == CH_SP) || (c == CH_CR);

        // key position wraps if the key was shortened under it
        kp       = ({1'b0, kpos} >= key_len) ? '0 : kpos;
        key_byte = r_key_chars[kp*CHAR_W +: CHAR_W];
        kp_next  = KEY_LEN_W'(kp) + KEY_LEN_W'(1);

        n_phase   = ph;
        n_key_pos = kpos;
        n_prev    = c;
        n_val_buf = vbuf;
        n_val_cnt = vcnt;
        n_emit    = 1'b0;
        n_found   = 1'b0;

        unique case (ph)
            PH_DONE: begin
            end
            PH_CAPTURE: begin
                if (is_end || c == CH_AMP) begin
                    n_emit  = 1'b1;
                    n_found = 1'b1;
                end else begin
                    if (vcnt < VAL_CNT_W'(VALUE_BYTES)) begin
                        for (int b = 0; b < VALUE_BYTES; b++) begin
                            if (vcnt == VAL_CNT_W'(b)) begin
                                n_val_buf[b*CHAR_W +: CHAR_W] = c;
                            end
                        end
                        n_val_cnt = vcnt + VAL_CNT_W'(1);
                    end
                    if (n_val_cnt >= val_limit) begin
                        n_emit  = 1'b1;
                        n_found = 1'b1;
                    end
                end
            end
            PH_EXPECT_EQ: begin
                if (is_end) begin
                    n_emit = 1'b1;
                end else if (c == CH_EQ) begin
                    n_phase   = PH_CAPTURE;
                    n_val_buf = '0;
                    n_val_cnt = '0;
                    if (val_limit == '0) begin
                        n_emit  = 1'b1;
                        n_found = 1'b1;
                    end
                end else begin
                    n_phase = PH_SEARCH;
                end
            end
            PH_SEARCH: begin
                if (is_end) begin
                    n_emit = 1'b1;
                end else if (key_len != '0 && c == key_byte) begin
                    if (kp == '0 && !(prev == CH_QM || prev == CH_AMP)) begin
                        n_key_pos = '0;
                    end else if (kp_next >= key_len) begin
                        n_key_pos = '0;
                        n_phase   = PH_EXPECT_EQ;
                    end else begin
                        n_key_pos = kp_next[KEY_POS_W-1:0];
                    end
                end else begin
                    n_key_pos = '0;
                end
            end
        endcase

        if (n_emit) begin
            n_phase = PH_DONE;
        end
    end

    // ---- config registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_chars   <= RST_KEY_CHARS;
            r_key_length  <= RST_KEY_LENGTH;
            r_max_val_len <= RST_MAX_VAL_LEN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_CHARS:   r_key_chars   <= i_cfg_wdata[KEY_W-1:0];
                CFG_KEY_LENGTH:  r_key_length  <= i_cfg_wdata[KEY_LEN_W-1:0];
                CFG_MAX_VAL_LEN: r_max_val_len <= i_cfg_wdata[MAX_VAL_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---- scan state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_key_pos <= '0;
            r_prev    <= '0;
            r_val_buf <= '0;
            r_val_cnt <= '0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_key_pos <= n_key_pos;
            r_prev    <= n_prev;
            r_val_buf <= n_val_buf;
            r_val_cnt <= n_val_cnt;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= n_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_found   <= n_found;
            r_out_val <= n_found ? n_val_buf : '0;
            r_out_len <= n_found ? n_val_cnt : '0;
        end
    end

    // ---- assertions ----
    // a miss never carries value data
    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_found |-> (r_out_len == '0) && (r_out_val == '0))
        else $error("miss result carries value data");

    // every result closes the string
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_emit |=> r_phase == PH_DONE)
        else $error("scan not closed after result");

    // nothing more until the next string starts
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in.first_char && r_phase == PH_DONE |=> !r_out_valid)
        else $error("second result within one string");

endmodule

`default_nettype wire

FILE: dv/query_key_value_extractor_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for query_key_value_extractor_core: query strings go in as character
// beats, key lookups are predicted in step and checked beat by beat on the result stream.
// Depends on qkv_pkg, the stream interfaces in qkv_if.sv and the core itself.

module query_key_value_extractor_core_tb;

    import qkv_pkg::*;

    localparam int PHASE_CHARS = 92;      // random characters per configuration phase
    localparam int MAX_REPORTS = 10;

    // One character beat as queued for the driver
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              first;
    } t_char_beat;

    // One lookup result as expected on the output
    typedef struct packed {
        logic                 found;
        logic [VALUE_W-1:0]   chars;
        logic [VAL_CNT_W-1:0] count;
    } t_lookup;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    qkv_in_if  char_if ();
    qkv_out_if res_if ();

    query_key_value_extractor_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (char_if),
        .o_out       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Characters waiting to be driven, and lookups still owed by the core
    t_char_beat char_q[$];
    t_lookup    due_lookups[$];
    int         mismatches = 0;
    logic       beat_taken;      // input beat accepted at the last rising edge
    logic       hold_off = 1'b0; // long receiver stall, set by its own process

    // Mirror of the configuration registers, reset values from the package
    logic [KEY_W-1:0]         key_reg     = RST_KEY_CHARS;
    logic [KEY_LEN_W-1:0]     key_len_reg = RST_KEY_LENGTH;
    logic [MAX_VAL_LEN_W-1:0] max_len_reg = RST_MAX_VAL_LEN;

    // Mirror of the scan state; reset behaves as a fresh string
    t_phase             sc_phase  = PH_SEARCH;
    int unsigned        key_pos   = 0;
    logic [CHAR_W-1:0]  last_char = CH_NUL;
    logic [VALUE_W-1:0] val_buf   = '0;
    int unsigned        val_cnt   = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Lookup prediction
    // ------------------------------------------------------------------

    function automatic int unsigned key_span();
        return (key_len_reg > MAX_KEY_CHARS) ? MAX_KEY_CHARS : key_len_reg;
    endfunction

    // Characters that end a string; '&' only ends a value, handled apart
    function automatic bit is_string_end(logic [CHAR_W-1:0] c);
        return c == CH_NUL || c == CH_SP || c == CH_CR;
    endfunction

    // Close the string: one result, nothing more until the next first character
    function automatic void post_lookup(logic hit);
        t_lookup r;
        r.found = hit;
        r.chars = hit ? val_buf : '0;
        r.count = hit ? val_cnt[VAL_CNT_W-1:0] : '0;
        due_lookups.push_back(r);
        sc_phase = PH_DONE;
    endfunction

    // Advance the mirror by one accepted character beat
    function automatic void scan_char(logic [CHAR_W-1:0] c, logic first);
        logic [CHAR_W-1:0] prior;
        int unsigned       span;
        int unsigned       limit;
        if (first) begin
            sc_phase  = PH_SEARCH;
            key_pos   = 0;
            last_char = CH_NUL;
            val_buf   = '0;
            val_cnt   = 0;
        end
        prior     = last_char;
        last_char = c;
        span      = key_span();
        // buffer size minus one, zero stays zero, capped at the value width
        limit = (max_len_reg == 0) ? 0 : max_len_reg - 1;
        if (limit > VALUE_BYTES) limit = VALUE_BYTES;

        case (sc_phase)
            PH_DONE: ;
            PH_CAPTURE: begin
                if (is_string_end(c) || c == CH_AMP) begin
                    post_lookup(1'b1);
                end else begin
                    if (val_cnt < VALUE_BYTES) begin
                        val_buf[CHAR_W*val_cnt +: CHAR_W] = c;
                        val_cnt++;
                    end
                    if (val_cnt >= limit) post_lookup(1'b1);
                end
            end
            PH_EXPECT_EQ: begin
                if (is_string_end(c)) begin
                    post_lookup(1'b0);
                end else if (c == CH_EQ) begin
                    sc_phase = PH_CAPTURE;
                    val_buf  = '0;
                    val_cnt  = 0;
                    if (limit == 0) post_lookup(1'b1);
                end else begin
                    // consumed, not rechecked as a key start
                    sc_phase = PH_SEARCH;
                end
            end
            default: begin
                if (is_string_end(c)) begin
                    post_lookup(1'b0);
                end else begin
                    if (key_pos >= span) key_pos = 0;
                    if (span != 0 && c == key_reg[CHAR_W*key_pos +: CHAR_W]) begin
                        // a key only starts right after '?' or '&'
                        if (key_pos != 0 || prior == CH_QM || prior == CH_AMP) begin
                            key_pos++;
                            if (key_pos >= span) begin
                                key_pos  = 0;
                                sc_phase = PH_EXPECT_EQ;
                            end
                        end
                    end else begin
                        key_pos = 0;
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    function automatic void push_char(logic [CHAR_W-1:0] c, logic first);
        t_char_beat b;
        b.code  = c;
        b.first = first;
        char_q.push_back(b);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_letter();
        return 8'h61 + CHAR_W'($urandom_range(0, 25));
    endfunction

    // Value bytes: mostly plain text, now and then any byte at all
    function automatic logic [CHAR_W-1:0] rand_value_char();
        if ($urandom_range(0, 4) == 0) return CHAR_W'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0) return 8'h30 + CHAR_W'($urandom_range(0, 9));
        return rand_letter();
    endfunction

    // A '?'-led string of key=value pairs, the configured key in many of them
    function automatic int unsigned push_query();
        int unsigned n0;
        int unsigned klen;
        int unsigned n_pairs;
        int unsigned n_val;
        int unsigned bad;
        logic [CHAR_W-1:0] lead;
        n0   = char_q.size();
        klen = key_span();
        if (klen == 0) klen = $urandom_range(1, MAX_KEY_CHARS);
        case ($urandom_range(0, 3))
            0:       lead = CH_QM;
            1:       lead = 8'h2F;                       // '/'
            2:       lead = key_reg[CHAR_W-1:0];         // key at string start: no match
            default: lead = CHAR_W'($urandom_range(0, 255));
        endcase
        push_char(lead, 1'b1);
        if (lead != CH_QM && $urandom_range(0, 9) != 0) push_char(CH_QM, 1'b0);
        n_pairs = $urandom_range(1, 3);
        for (int p = 0; p < n_pairs; p++) begin
            if (p != 0) push_char(CH_AMP, 1'b0);
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    // the key, sometimes with one character spoiled
                    bad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, klen - 1) : klen;
                    for (int j = 0; j < klen; j++)
                        push_char(j == bad ? rand_letter() : key_reg[CHAR_W*j +: CHAR_W],
                                  1'b0);
                end
                3: begin
                    // a proper prefix of the key, then another name
                    for (int j = 0; j < $urandom_range(0, klen - 1); j++)
                        push_char(key_reg[CHAR_W*j +: CHAR_W], 1'b0);
                    push_char(rand_letter(), 1'b0);
                end
                default: begin
                    for (int j = 0; j < $urandom_range(1, 3); j++)
                        push_char(rand_letter(), 1'b0);
                end
            endcase
            if ($urandom_range(0, 9) != 0) push_char(CH_EQ, 1'b0);
            n_val = $urandom_range(0, 9);
            for (int j = 0; j < n_val; j++) push_char(rand_value_char(), 1'b0);
        end
        case ($urandom_range(0, 9))
            0, 1, 2: push_char(CH_NUL, 1'b0);
            3, 4:    push_char(CH_SP, 1'b0);
            5, 6:    push_char(CH_CR, 1'b0);
            7:       ;                                   // abandoned by the next string
            default: begin
                push_char(CH_AMP, 1'b0);
                push_char(CH_NUL, 1'b0);
            end
        endcase
        return char_q.size() - n0;
    endfunction

    // Raw bytes, the odd stray first-character flag among them
    function automatic int unsigned push_noise();
        int unsigned n;
        n = $urandom_range(1, 12);
        for (int j = 0; j < n; j++)
            push_char(CHAR_W'($urandom_range(0, 255)), j == 0 || $urandom_range(0, 19) == 0);
        return n;
    endfunction

    function automatic void fill_random(int unsigned budget);
        int unsigned sent;
        sent = 0;
        while (sent < budget)
            sent += ($urandom_range(0, 6) == 0) ? push_noise() : push_query();
    endfunction

    // ------------------------------------------------------------------
    // Configuration, only while the core is idle
    // ------------------------------------------------------------------

    task automatic wait_idle(input int unsigned settle);
        while (char_q.size() != 0 || due_lookups.size() != 0) @(posedge i_clk);
        // a beat that raised no result may still be in flight
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_KEY_CHARS:   key_reg     = data[KEY_W-1:0];
            CFG_KEY_LENGTH:  key_len_reg = data[KEY_LEN_W-1:0];
            CFG_MAX_VAL_LEN: max_len_reg = data[MAX_VAL_LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [KEY_W-1:0] key, input int unsigned klen,
                             input int unsigned vlen);
        wait_idle(4);
        write_reg(CFG_KEY_CHARS, key);
        write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(klen));
        write_reg(CFG_MAX_VAL_LEN, CFG_DATA_W'(vlen));
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    initial begin
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_UNUSED;
        i_cfg_wdata        = '0;
        char_if.valid      = 1'b0;
        char_if.char_code  = CH_NUL;
        char_if.first_char = 1'b0;
        res_if.ready       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings under the reset key "sw", four value characters at most
        push_text("?sw=12345");           // capture stops at the limit, '5' dropped
        push_text("sw ");                 // key at string start never counts
        push_text("?s");                  // abandoned by the next string
        push_text("?sw=&");               // empty value
        push_text("&sx&sw?\r");           // restart after mismatch, key not followed by '='
        fill_random(PHASE_CHARS);

        configure(32'h0000_0071, 1, 8);                   // "q", longest capture
        fill_random(PHASE_CHARS);
        configure(32'h7265_7375, 4, 1);                   // "user", result at '='
        fill_random(PHASE_CHARS);
        configure(32'h0062_3D61, 3, 2);                   // "a=b"
        fill_random(PHASE_CHARS);
        configure($urandom, 0, 0);                        // key that never matches
        fill_random(PHASE_CHARS);
        configure($urandom, 7, 15);                       // both lengths saturate
        fill_random(PHASE_CHARS);
        configure(32'hFFFF_FFFF, 4, 8);
        fill_random(PHASE_CHARS);
        configure({rand_letter(), rand_letter(), rand_letter(), rand_letter()},
                  $urandom_range(1, 4), $urandom_range(1, 8));
        write_reg(CFG_UNUSED, $urandom);                  // spare index, no effect
        fill_random(PHASE_CHARS);

        wait_idle(16);
        if (mismatches == 0) begin
            $display("** query_key_value_extractor_core: PASSED **");
        end else begin
            $display("** query_key_value_extractor_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #1_600_000;
        $display("** query_key_value_extractor_core: FAILED **");
        $finish;
    end

    // One long receiver stall early on, while the sender keeps offering beats
    initial begin
        @(posedge i_rst_n);
        repeat (40) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------
    // Character driver: bursts of random length, random gaps between
    // ------------------------------------------------------------------

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            char_if.valid <= 1'b0;
        end else if (char_if.valid && !beat_taken) begin
            // beat still on offer, hold it
        end else if (gap_left != 0) begin
            gap_left--;
            char_if.valid <= 1'b0;
        end else if (char_q.size() != 0) begin
            char_if.valid      <= 1'b1;
            char_if.char_code  <= char_q[0].code;
            char_if.first_char <= char_q[0].first;
            if (burst_left <= 1) begin
                // now and then a long unbroken run
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            char_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: always ready, random, or a rotating stall pattern
    // ------------------------------------------------------------------

    int unsigned      rx_mode    = 0;
    int unsigned      rx_left    = 0;
    logic [7:0]       rx_pattern = 8'hFF;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode    = $urandom_range(0, 2);
                rx_left    = $urandom_range(20, 200);
                rx_pattern = 8'($urandom) | 8'h01;
            end else begin
                rx_left--;
            end
            rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
            if (hold_off)          res_if.ready <= 1'b0;
            else if (rx_mode == 0) res_if.ready <= 1'b1;
            else if (rx_mode == 1) res_if.ready <= ($urandom_range(0, 2) != 0);
            else                   res_if.ready <= rx_pattern[7];
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input beat, check each result beat
    // ------------------------------------------------------------------

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    t_lookup want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= char_if.valid && char_if.ready;
            if (char_if.valid && char_if.ready) begin
                scan_char(char_if.char_code, char_if.first_char);
                void'(char_q.pop_front());
            end
            if (res_if.valid && res_if.ready) begin
                if (due_lookups.size() == 0) begin
                    flag_mismatch($sformatf(
                        "unexpected result beat: found=%0b value=%014h len=%0d",
                        res_if.found, res_if.value_chars, res_if.value_length));
                end else begin
                    want = due_lookups.pop_front();
                    if (res_if.found !== want.found || res_if.value_chars !== want.chars ||
                        res_if.value_length !== want.count)
                        flag_mismatch($sformatf(
                            {"lookup mismatch: expected found=%0b value=%014h len=%0d,",
                             " got found=%0b value=%014h len=%0d"},
                            want.found, want.chars, want.count,
                            res_if.found, res_if.value_chars, res_if.value_length));
                end
            end
        end
    end

endmodule

FILE: query_key_value_extractor_core.f
src/qkv_pkg.sv
src/qkv_if.sv
src/query_key_value_extractor_core.sv
dv/query_key_value_extractor_core_tb.sv
